// File: design/sep_pkg.sv
// shared embedding projection: package with field widths, action and register codes,
// default sizes and the control structs between the top level and the serial mac
// no dependencies
package sep_pkg;

   // default store sizes
   localparam int IN_MAX_DEF     = 16;
   localparam int OUT_MAX_DEF    = 16;
   localparam int ENTITY_MAX_DEF = 64;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 4;
   localparam int VALUE_W    = 16;
   localparam int RESULT_W   = 32;
   localparam int FIDX_W     = 4;
   localparam int EIDX_W     = 6;
   localparam int IWIDTH_W   = 5;
   localparam int OWIDTH_W   = 5;
   localparam int ECOUNT_W   = 7;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // q8.8 bias widened to q16.16
   localparam int FRAC_W = 8;

   // digit-serial multiplier: the feature is consumed one digit per cycle
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = VALUE_W / DIGIT_W;
   localparam int DCNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int WSH_W   = VALUE_W + DIGIT_W * (DIGITS - 1);
   localparam int PROD_W  = WSH_W + DIGIT_W + 1;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_WEIGHT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BIAS    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FEATURE = 2'd2;

   // register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_IN_WIDTH     = 2'd0;
   localparam logic [1:0] REG_OUT_WIDTH    = 2'd1;
   localparam logic [1:0] REG_ENTITY_COUNT = 2'd2;

   localparam logic [IWIDTH_W-1:0] IN_WIDTH_RST     = 5'd16;
   localparam logic [OWIDTH_W-1:0] OUT_WIDTH_RST    = 5'd16;
   localparam logic [ECOUNT_W-1:0] ENTITY_COUNT_RST = 7'd1;

   typedef struct packed {
      logic load;   // take a new weight and feature pair
      logic init;   // start of a dot product: preset with the bias
      logic step;   // consume one feature digit
   } mac_ctrl_type;

   typedef struct packed {
      logic last_digit;
   } mac_stat_type;

endpackage

// File: design/sep_ram.sv
// shared embedding projection: generic single-write, single-read ram with registered read
// depends on nothing
module sep_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sep_mac.sv
// shared embedding projection: digit-serial multiply-accumulate with output saturation
// depends on sep_pkg
module sep_mac #(
   parameter int ACC_W = 38
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sep_pkg::mac_ctrl_type               ctrl,
   input  logic signed [sep_pkg::VALUE_W-1:0]  weight,
   input  logic        [sep_pkg::VALUE_W-1:0]  feature,
   input  logic signed [sep_pkg::VALUE_W-1:0]  bias,
   output sep_pkg::mac_stat_type               stat,
   output logic signed [sep_pkg::RESULT_W-1:0] result
);

   logic signed [sep_pkg::WSH_W-1:0]   w_ff, w_in;
   logic        [sep_pkg::VALUE_W-1:0] x_ff, x_in;
   logic        [sep_pkg::DCNT_W-1:0]  digit_ff, digit_in;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic                               top_digit;
   logic signed [sep_pkg::DIGIT_W:0]   digit;
   logic signed [sep_pkg::PROD_W-1:0]  prod;
   logic                               in_range;

   assign top_digit = (digit_ff == sep_pkg::DCNT_W'(sep_pkg::DIGITS - 1));
   // lower digits are unsigned, the top one carries the sign
   assign digit = {top_digit & x_ff[sep_pkg::DIGIT_W-1], x_ff[sep_pkg::DIGIT_W-1:0]};
   assign prod  = w_ff * digit;

   always_comb begin
      w_in     = w_ff;
      x_in     = x_ff;
      digit_in = digit_ff;
      acc_in   = acc_ff;
      if (ctrl.load) begin
         w_in     = {{(sep_pkg::WSH_W-sep_pkg::VALUE_W){weight[sep_pkg::VALUE_W-1]}}, weight};
         x_in     = feature;
         digit_in = '0;
         if (ctrl.init) begin
            acc_in = {{(ACC_W-sep_pkg::VALUE_W-sep_pkg::FRAC_W){bias[sep_pkg::VALUE_W-1]}},
                      bias, {sep_pkg::FRAC_W{1'b0}}};
         end
      end else if (ctrl.step) begin
         acc_in   = acc_ff + {{(ACC_W-sep_pkg::PROD_W){prod[sep_pkg::PROD_W-1]}}, prod};
         w_in     = w_ff <<< sep_pkg::DIGIT_W;
         x_in     = x_ff >> sep_pkg::DIGIT_W;
         digit_in = digit_ff + sep_pkg::DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
      w_ff   <= w_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign stat.last_digit = ctrl.step & top_digit;

   // fits in 32 bits when every bit above bit 31 equals the sign
   assign in_range = (acc_ff[ACC_W-1:sep_pkg::RESULT_W-1] == '0) ||
                     (acc_ff[ACC_W-1:sep_pkg::RESULT_W-1] == '1);

   always_comb begin
      if (in_range) begin
         result = acc_ff[sep_pkg::RESULT_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         result = {1'b1, {(sep_pkg::RESULT_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(sep_pkg::RESULT_W-1){1'b1}}};
      end
   end

endmodule

// File: design/shared_embedding_projection.sv
// shared embedding projection: top level with stream ports, register port, sequencer,
// weight, bias and feature rams and the digit-serial mac; depends on sep_pkg, sep_ram, sep_mac
//
// One dense projection, out[j] = sum_i W[i][j]*x[i] + b[j], is applied to every entity.
// Request transactions carry a kind in req_tuser: weight write, bias write or feature
// sample (the unused kind is accepted and dropped). Weight and bias writes and features
// that do not fill the entity leave the block idle. The feature that fills the entity
// starts the projection: req_tready stays low while out_width results are worked out,
// one after another, on a single multiply-accumulate unit that consumes each feature in
// four 4-bit digits. A result takes one ram read step, then per term a load step and
// four digit steps, then one step into the output register; that last step waits while
// rsp_tready is held low and the output register is still full.
// Results are Q16.16, bias widened exactly, summed exactly and saturated once to 32 bits.
// rsp_tlast marks the last feature of an entity, rsp_tuser the last result of the
// observation (after entity_count entities). The rams need no clearing after reset;
// an unwritten weight or bias reads as whatever it holds.
module shared_embedding_projection #(
   parameter int IN_MAX     = sep_pkg::IN_MAX_DEF,
   parameter int OUT_MAX    = sep_pkg::OUT_MAX_DEF,
   parameter int ENTITY_MAX = sep_pkg::ENTITY_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sep_pkg::REQ_DATA_W-1:0]   req_tdata,   // in_row[3:0], out_col[7:4], value[23:8]
   input  logic [sep_pkg::ACTION_W-1:0]     req_tuser,   // action[1:0]
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sep_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // result_value[31:0],
                                                         // feature_index[35:32],
                                                         // entity_index[41:36], zero[47:42]
   output logic                             rsp_tlast,   // last_of_entity
   output logic                             rsp_tuser,   // last_of_observation[0]
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sep_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sep_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sep_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int RW     = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
   localparam int CW     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int IW_W   = $clog2(IN_MAX + 1);
   localparam int OW_W   = $clog2(OUT_MAX + 1);
   localparam int W_DEPTH = IN_MAX * (2 ** CW);
   localparam int ACC_W  = 34 + $clog2(IN_MAX);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_LOAD,
      S_DIGIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // configuration registers, stored raw
   logic [sep_pkg::IWIDTH_W-1:0] in_width_ff, in_width_in;
   logic [sep_pkg::OWIDTH_W-1:0] out_width_ff, out_width_in;
   logic [sep_pkg::ECOUNT_W-1:0] entity_count_ff, entity_count_in;

   // sequencing
   logic [IW_W-1:0]             fill_ff, fill_in;
   logic [IW_W-1:0]             i_ff, i_in;
   logic [CW-1:0]               j_ff, j_in;
   logic                        last_mac_ff, last_mac_in;
   logic [sep_pkg::ECOUNT_W-1:0] ent_ff, ent_in;
   logic [sep_pkg::EIDX_W-1:0]  ent_idx_ff, ent_idx_in;
   logic                        last_obs_ff, last_obs_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sep_pkg::RESULT_W-1:0] res_ff, res_in;
   logic [sep_pkg::FIDX_W-1:0]  fidx_ff, fidx_in;
   logic [sep_pkg::EIDX_W-1:0]  eidx_ff, eidx_in;
   logic                        tlast_ff, tlast_in;
   logic                        tuser_ff, tuser_in;

   // effective (clamped) register values
   logic [IW_W-1:0]             iw_eff;
   logic [OW_W-1:0]             ow_eff;
   logic [sep_pkg::ECOUNT_W-1:0] ec_eff;

   // request fields
   logic [sep_pkg::INDEX_W-1:0] in_row;
   logic [sep_pkg::INDEX_W-1:0] out_col;
   logic [sep_pkg::VALUE_W-1:0] value;
   logic                        req_accept;
   logic                        csr_write;
   logic [IW_W-1:0]             fill_next;
   logic                        last_j;

   // ram ports
   logic                        w_wr_en, b_wr_en, f_wr_en;
   logic [sep_pkg::VALUE_W-1:0] w_rd_data, b_rd_data, f_rd_data;

   sep_pkg::mac_ctrl_type       mac_ctrl;
   sep_pkg::mac_stat_type       mac_stat;
   logic signed [sep_pkg::RESULT_W-1:0] mac_result;

   assign in_row  = req_tdata[3:0];
   assign out_col = req_tdata[7:4];
   assign value   = req_tdata[23:8];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // a zero counts as one, anything beyond the store counts as its size
   always_comb begin
      if (in_width_ff == '0) begin
         iw_eff = IW_W'(1);
      end else if (32'(in_width_ff) > IN_MAX) begin
         iw_eff = IW_W'(IN_MAX);
      end else begin
         iw_eff = IW_W'(in_width_ff);
      end
      if (out_width_ff == '0) begin
         ow_eff = OW_W'(1);
      end else if (32'(out_width_ff) > OUT_MAX) begin
         ow_eff = OW_W'(OUT_MAX);
      end else begin
         ow_eff = OW_W'(out_width_ff);
      end
      if (entity_count_ff == '0) begin
         ec_eff = sep_pkg::ECOUNT_W'(1);
      end else if (32'(entity_count_ff) > ENTITY_MAX) begin
         ec_eff = sep_pkg::ECOUNT_W'(ENTITY_MAX);
      end else begin
         ec_eff = entity_count_ff;
      end
   end

   assign fill_next = fill_ff + IW_W'(1);
   assign last_j    = (32'(j_ff) + 1 == 32'(ow_eff));

   // store writes happen only on accepted request transactions
   assign w_wr_en = req_accept && (req_tuser == sep_pkg::ACT_WEIGHT) &&
                    (32'(in_row) < IN_MAX) && (32'(out_col) < OUT_MAX);
   assign b_wr_en = req_accept && (req_tuser == sep_pkg::ACT_BIAS) && (32'(out_col) < OUT_MAX);
   assign f_wr_en = req_accept && (req_tuser == sep_pkg::ACT_FEATURE) && (32'(fill_ff) < IN_MAX);

   sep_ram #(
      .WIDTH (sep_pkg::VALUE_W),
      .DEPTH (W_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr ({RW'(in_row), CW'(out_col)}),
      .wr_data (value),
      .rd_addr ({i_ff[RW-1:0], j_ff}),
      .rd_data (w_rd_data)
   );

   sep_ram #(
      .WIDTH (sep_pkg::VALUE_W),
      .DEPTH (OUT_MAX)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (CW'(out_col)),
      .wr_data (value),
      .rd_addr (j_ff),
      .rd_data (b_rd_data)
   );

   sep_ram #(
      .WIDTH (sep_pkg::VALUE_W),
      .DEPTH (IN_MAX)
   ) u_feature_ram (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (fill_ff[RW-1:0]),
      .wr_data (value),
      .rd_addr (i_ff[RW-1:0]),
      .rd_data (f_rd_data)
   );

   sep_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .weight  (w_rd_data),
      .feature (f_rd_data),
      .bias    (b_rd_data),
      .stat    (mac_stat),
      .result  (mac_result)
   );

   always_comb begin
      state_in        = state_ff;
      in_width_in     = in_width_ff;
      out_width_in    = out_width_ff;
      entity_count_in = entity_count_ff;
      fill_in         = fill_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      last_mac_in     = last_mac_ff;
      ent_in          = ent_ff;
      ent_idx_in      = ent_idx_ff;
      last_obs_in     = last_obs_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      res_in          = res_ff;
      fidx_in         = fidx_ff;
      eidx_in         = eidx_ff;
      tlast_in        = tlast_ff;
      tuser_in        = tuser_ff;
      mac_ctrl        = '0;

      // register writes; software only writes while the block is idle (the block itself does not enforce this)
      if (csr_write) begin
         case (csr_paddr[3:2])
            sep_pkg::REG_IN_WIDTH:     in_width_in     = csr_pwdata[sep_pkg::IWIDTH_W-1:0];
            sep_pkg::REG_OUT_WIDTH:    out_width_in    = csr_pwdata[sep_pkg::OWIDTH_W-1:0];
            sep_pkg::REG_ENTITY_COUNT: entity_count_in = csr_pwdata[sep_pkg::ECOUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == sep_pkg::ACT_FEATURE)) begin
               if (fill_next >= iw_eff) begin
                  // entity complete: latch its index and observation mark, then start
                  fill_in     = '0;
                  i_in        = '0;
                  j_in        = '0;
                  ent_idx_in  = ent_ff[sep_pkg::EIDX_W-1:0];
                  last_obs_in = ({1'b0, ent_ff} + 8'd1) >= {1'b0, ec_eff};
                  ent_in      = last_obs_in ? '0 : ent_ff + sep_pkg::ECOUNT_W'(1);
                  state_in    = S_FETCH;
               end else begin
                  fill_in = fill_next;
               end
            end
         end
         S_FETCH: begin
            // ram read of the first term and the bias
            state_in = S_LOAD;
         end
         S_LOAD: begin
            mac_ctrl.load = 1'b1;
            mac_ctrl.init = (i_ff == '0);
            // next term is read while the digits of this one run
            i_in        = i_ff + IW_W'(1);
            last_mac_in = (32'(i_ff) + 1 == 32'(iw_eff));
            state_in    = S_DIGIT;
         end
         S_DIGIT: begin
            mac_ctrl.step = 1'b1;
            if (mac_stat.last_digit) begin
               state_in = last_mac_ff ? S_EMIT : S_LOAD;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               res_in       = mac_result;
               fidx_in      = sep_pkg::FIDX_W'(j_ff);
               eidx_in      = ent_idx_ff;
               tlast_in     = last_j;
               tuser_in     = last_j & last_obs_ff;
               if (last_j) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + CW'(1);
                  i_in     = '0;
                  state_in = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         in_width_ff     <= sep_pkg::IN_WIDTH_RST;
         out_width_ff    <= sep_pkg::OUT_WIDTH_RST;
         entity_count_ff <= sep_pkg::ENTITY_COUNT_RST;
         fill_ff         <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         last_mac_ff     <= 1'b0;
         ent_ff          <= '0;
         ent_idx_ff      <= '0;
         last_obs_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         in_width_ff     <= in_width_in;
         out_width_ff    <= out_width_in;
         entity_count_ff <= entity_count_in;
         fill_ff         <= fill_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         last_mac_ff     <= last_mac_in;
         ent_ff          <= ent_in;
         ent_idx_ff      <= ent_idx_in;
         last_obs_ff     <= last_obs_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      res_ff   <= res_in;
      fidx_ff  <= fidx_in;
      eidx_ff  <= eidx_in;
      tlast_ff <= tlast_in;
      tuser_ff <= tuser_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sep_pkg::RSP_DATA_W - sep_pkg::RESULT_W - sep_pkg::FIDX_W
                          - sep_pkg::EIDX_W){1'b0}}, eidx_ff, fidx_ff, res_ff};
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

   // register read back
   always_comb begin
      case (csr_paddr[3:2])
         sep_pkg::REG_IN_WIDTH:     csr_prdata = sep_pkg::CSR_DATA_W'(in_width_ff);
         sep_pkg::REG_OUT_WIDTH:    csr_prdata = sep_pkg::CSR_DATA_W'(out_width_ff);
         sep_pkg::REG_ENTITY_COUNT: csr_prdata = sep_pkg::CSR_DATA_W'(entity_count_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // the feature that fills the entity starts the projection
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == sep_pkg::ACT_FEATURE) && (fill_next >= iw_eff))
      |=> (state_ff == S_FETCH))
      else $error("filled entity did not start the projection");

   // a new result only appears out of the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_EMIT))
      else $error("result register loaded outside the emit step");

   // the observation mark only comes with the entity mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser || rsp_tlast))
      else $error("last of observation without last of entity");

   // the fill count never points past the feature store
   assert property (@(posedge clock) disable iff (reset)
      (32'(fill_ff) < IN_MAX))
      else $error("feature fill beyond the store");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for shared_embedding_projection: directed table then random phases, each result
// checked against an in-bench projection predictor; depends on sep_pkg and the design files

module tb_top;

   // action code the block accepts and drops, and a register index that decodes to nothing
   localparam logic [sep_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0]                   REG_NONE   = 2'd3;

   localparam int DRAIN_CYCLES = 100;   // settle time before a register write and at the end
   localparam int ITEM_TARGET  = 96;    // random request transactions
   localparam int PHASE_ITEMS  = 24;
   localparam int DIR_ROWS     = 37;
   localparam int FILL_SPAN    = 8;     // weight corner written in full before any projection
   localparam int WIDTH_SPAN   = 8;     // widths that random phases may use together

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   // one projected feature as it leaves the block
   typedef struct packed {
      logic [sep_pkg::RESULT_W-1:0] value;
      logic [sep_pkg::FIDX_W-1:0]   feature_idx;
      logic [sep_pkg::EIDX_W-1:0]   entity_idx;
      logic                         last_entity;
      logic                         last_obs;
   } projection_type;

   // directed stimulus row: either a request transaction or a register write
   typedef struct packed {
      row_kind_type                 kind;
      logic [1:0]                   code;       // action, or register index for ROW_CFG
      logic [sep_pkg::INDEX_W-1:0]  in_row;
      logic [sep_pkg::INDEX_W-1:0]  out_col;
      logic [sep_pkg::VALUE_W-1:0]  value;      // item value, or register data for ROW_CFG
      logic                         has_exp;
      logic [sep_pkg::RESULT_W-1:0] exp_value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                             req_tvalid;
   logic                             req_tready;
   logic [sep_pkg::REQ_DATA_W-1:0]   req_tdata;   // in_row[3:0], out_col[7:4], value[23:8]
   logic [sep_pkg::ACTION_W-1:0]     req_tuser;   // action[1:0]

   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sep_pkg::RSP_DATA_W-1:0]   rsp_tdata;   // result_value[31:0], feature_index[35:32],
                                                  // entity_index[41:36], zero[47:42]
   logic                             rsp_tlast;   // last_of_entity
   logic                             rsp_tuser;   // last_of_observation[0]

   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [sep_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [sep_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [sep_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   shared_embedding_projection dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // predictor state: stores, entity buffer, counters and a mirror of the registers
   // ---------------------------------------------------------------------------------------
   logic signed [sep_pkg::VALUE_W-1:0] weight_mem [sep_pkg::IN_MAX_DEF][sep_pkg::OUT_MAX_DEF];
   logic signed [sep_pkg::VALUE_W-1:0] bias_mem [sep_pkg::OUT_MAX_DEF];
   logic signed [sep_pkg::VALUE_W-1:0] feature_mem [sep_pkg::IN_MAX_DEF];
   int unsigned                        feature_fill = 0;
   int unsigned                        entity_pos = 0;
   logic [sep_pkg::IWIDTH_W-1:0]       cfg_in_width = sep_pkg::IN_WIDTH_RST;
   logic [sep_pkg::OWIDTH_W-1:0]       cfg_out_width = sep_pkg::OUT_WIDTH_RST;
   logic [sep_pkg::ECOUNT_W-1:0]       cfg_entity_count = sep_pkg::ENTITY_COUNT_RST;

   projection_type pending_projections[$];
   int             mismatch_count = 0;
   idle_mode_type  idle_mode = IDLE_NONE;

   // apply one accepted request transaction to the predictor and queue the projections
   // that it completes
   function automatic void project_item(input logic [sep_pkg::ACTION_W-1:0] action,
                                        input logic [sep_pkg::INDEX_W-1:0] in_row,
                                        input logic [sep_pkg::INDEX_W-1:0] out_col,
                                        input logic signed [sep_pkg::VALUE_W-1:0] value);
      int             iw;
      int             ow;
      int             ec;
      longint         acc;
      bit             obs_end;
      projection_type res;
      case (action)
         sep_pkg::ACT_WEIGHT: weight_mem[in_row][out_col] = value;
         sep_pkg::ACT_BIAS:   bias_mem[out_col] = value;
         sep_pkg::ACT_FEATURE: begin
            // zero counts as one, anything above the store size is clamped
            iw = (cfg_in_width == 0) ? 1
                 : (cfg_in_width > sep_pkg::IN_MAX_DEF) ? sep_pkg::IN_MAX_DEF : cfg_in_width;
            ow = (cfg_out_width == 0) ? 1
                 : (cfg_out_width > sep_pkg::OUT_MAX_DEF) ? sep_pkg::OUT_MAX_DEF
                                                          : cfg_out_width;
            ec = (cfg_entity_count == 0) ? 1
                 : (cfg_entity_count > sep_pkg::ENTITY_MAX_DEF) ? sep_pkg::ENTITY_MAX_DEF
                                                                : cfg_entity_count;
            if (feature_fill < sep_pkg::IN_MAX_DEF)
               feature_mem[feature_fill] = value;
            feature_fill++;
            // a width lowered below the fill completes the entity on this feature
            if (feature_fill >= iw) begin
               obs_end = (entity_pos + 1 >= ec);
               for (int j = 0; j < ow; j++) begin
                  // q8.8 bias widened exactly to q16.16, exact products, one saturation
                  acc = longint'(bias_mem[j]) * 256;
                  for (int i = 0; i < iw; i++)
                     acc += longint'(weight_mem[i][j]) * longint'(feature_mem[i]);
                  if (acc > 64'sd2147483647)
                     res.value = 32'h7FFF_FFFF;
                  else if (acc < -64'sd2147483648)
                     res.value = 32'h8000_0000;
                  else
                     res.value = acc[31:0];
                  res.feature_idx = j[sep_pkg::FIDX_W-1:0];
                  res.entity_idx  = entity_pos[sep_pkg::EIDX_W-1:0];
                  res.last_entity = (j == ow - 1);
                  res.last_obs    = obs_end && (j == ow - 1);
                  pending_projections.push_back(res);
               end
               feature_fill = 0;
               entity_pos = obs_end ? 0 : ((entity_pos + 1) & 32'h7F);
            end
         end
         default: ;   // unused action leaves every store alone
      endcase
   endfunction

   // decides whether a side idles this cycle under the current idling mode
   function automatic bit roll_stall(input bit receiver_side);
      case (idle_mode)
         IDLE_SEND: return !receiver_side && ($urandom_range(99, 0) < 54);
         IDLE_RECV: return receiver_side && ($urandom_range(99, 0) < 54);
         IDLE_BOTH: return $urandom_range(99, 0) < 37;
         default:   return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // result side: backpressure at the falling edge, check at the rising edge
   // ---------------------------------------------------------------------------------------
   always @(negedge clock)
      rsp_tready <= !roll_stall(1'b1);

   always @(posedge clock) begin
      projection_type seen;
      projection_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.value       = rsp_tdata[31:0];
         seen.feature_idx = rsp_tdata[35:32];
         seen.entity_idx  = rsp_tdata[41:36];
         seen.last_entity = rsp_tlast;
         seen.last_obs    = rsp_tuser;
         if (pending_projections.size() == 0) begin
            if (mismatch_count < 10)
               $display("[%0t] unexpected result transaction: value %h feature %0d entity %0d",
                        $realtime, seen.value, seen.feature_idx, seen.entity_idx);
            mismatch_count++;
         end else begin
            want = pending_projections.pop_front();
            if (seen !== want) begin
               if (mismatch_count < 10) begin
                  $display("[%0t] result mismatch", $realtime);
                  $display("   value   exp %h act %h", want.value, seen.value);
                  $display("   feature exp %0d act %0d", want.feature_idx, seen.feature_idx);
                  $display("   entity  exp %0d act %0d", want.entity_idx, seen.entity_idx);
                  $display("   last entity exp %b act %b, last observation exp %b act %b",
                           want.last_entity, seen.last_entity, want.last_obs, seen.last_obs);
               end
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // request side and register port; every task starts and ends at a falling edge
   // ---------------------------------------------------------------------------------------
   task automatic send_item(input logic [sep_pkg::ACTION_W-1:0] action,
                            input logic [sep_pkg::INDEX_W-1:0] in_row,
                            input logic [sep_pkg::INDEX_W-1:0] out_col,
                            input logic [sep_pkg::VALUE_W-1:0] value);
      while (roll_stall(1'b0)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, out_col, in_row};
      req_tuser  <= action;
      do
         @(posedge clock);
      while (!req_tready);
      project_item(action, in_row, out_col, value);
      @(negedge clock);
   endtask

   // stop sending, wait until every queued projection has come back, then let the block settle
   task automatic drain(input int settle_cycles);
      req_tvalid <= 1'b0;
      while (pending_projections.size() != 0)
         @(negedge clock);
      repeat (settle_cycles) @(negedge clock);
   endtask

   // two-phase register write; the register takes the data at the access-phase rising edge
   task automatic reg_write(input logic [1:0] reg_index,
                            input logic [sep_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      case (reg_index)
         sep_pkg::REG_IN_WIDTH:     cfg_in_width = data[sep_pkg::IWIDTH_W-1:0];
         sep_pkg::REG_OUT_WIDTH:    cfg_out_width = data[sep_pkg::OWIDTH_W-1:0];
         sep_pkg::REG_ENTITY_COUNT: cfg_entity_count = data[sep_pkg::ECOUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // directed rows; expected values are typed in only where they are plain to see
   stim_row_type directed_rows [DIR_ROWS];

   initial begin
      directed_rows = '{
         // one feature, one output, one entity per observation
         '{ROW_CFG,  sep_pkg::REG_IN_WIDTH,     4'd0,  4'd0,  16'd1,    1'b0, 32'd0},
         '{ROW_CFG,  sep_pkg::REG_OUT_WIDTH,    4'd0,  4'd0,  16'd1,    1'b0, 32'd0},
         '{ROW_CFG,  sep_pkg::REG_ENTITY_COUNT, 4'd0,  4'd0,  16'd1,    1'b0, 32'd0},
         // largest positive and negative operands
         '{ROW_ITEM, sep_pkg::ACT_WEIGHT,       4'd0,  4'd0,  16'h7FFF, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_BIAS,         4'd0,  4'd0,  16'h7FFF, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h7FFF, 1'b1, 32'sd1082064641},
         '{ROW_ITEM, sep_pkg::ACT_WEIGHT,       4'd0,  4'd0,  16'h8000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_BIAS,         4'd0,  4'd0,  16'h8000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h8000, 1'b1, 32'sd1065353216},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h7FFF, 1'b1, -32'sd1082097664},
         // dropped action, then the far corner of the weight store
         '{ROW_ITEM, ACT_UNUSED,                4'd15, 4'd15, 16'hFFFF, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_WEIGHT,       4'd15, 4'd15, 16'h1234, 1'b0, 32'd0},
         // three full-scale terms push the sum past both 32-bit limits
         '{ROW_CFG,  sep_pkg::REG_IN_WIDTH,     4'd0,  4'd0,  16'd3,    1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_WEIGHT,       4'd1,  4'd0,  16'h8000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_WEIGHT,       4'd2,  4'd0,  16'h8000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_BIAS,         4'd0,  4'd0,  16'h0000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h8000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h8000, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h8000, 1'b1, 32'h7FFF_FFFF},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h7FFF, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h7FFF, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h7FFF, 1'b1, 32'h8000_0000},
         // width lowered below the fill: the next feature ends the entity on entry 0
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0100, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0200, 1'b0, 32'd0},
         '{ROW_CFG,  sep_pkg::REG_IN_WIDTH,     4'd0,  4'd0,  16'd1,    1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0300, 1'b1, -32'sd8388608},
         // entity count lowered under the counter: next entity closes the observation
         '{ROW_CFG,  sep_pkg::REG_ENTITY_COUNT, 4'd0,  4'd0,  16'd4,    1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0001, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0002, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0003, 1'b0, 32'd0},
         '{ROW_CFG,  sep_pkg::REG_ENTITY_COUNT, 4'd0,  4'd0,  16'd2,    1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0004, 1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'h0005, 1'b0, 32'd0},
         // write to an empty address, then zero and over-range widths
         '{ROW_CFG,  REG_NONE,                  4'd0,  4'd0,  16'd5,    1'b0, 32'd0},
         '{ROW_CFG,  sep_pkg::REG_IN_WIDTH,     4'd0,  4'd0,  16'd0,    1'b0, 32'd0},
         '{ROW_CFG,  sep_pkg::REG_OUT_WIDTH,    4'd0,  4'd0,  16'd31,   1'b0, 32'd0},
         '{ROW_ITEM, sep_pkg::ACT_FEATURE,      4'd0,  4'd0,  16'hFFFF, 1'b0, 32'd0}
      };
   end

   // run ends here on a hang
   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      projection_type                  held;
      int                              phase;
      int                              items_sent;
      int unsigned                     roll;
      logic [sep_pkg::ACTION_W-1:0]    action;
      logic [sep_pkg::VALUE_W-1:0]     value;
      logic [sep_pkg::VALUE_W-1:0]     corner [4];
      int unsigned                     iw_set;
      int unsigned                     ow_set;
      int unsigned                     ec_set;

      corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // write every weight a projection can reach: a corner in full plus row 0 and
      // column 0 across the store, then every bias
      for (int i = 0; i < sep_pkg::IN_MAX_DEF; i++)
         for (int j = 0; j < sep_pkg::OUT_MAX_DEF; j++)
            if ((i < FILL_SPAN && j < FILL_SPAN) || i == 0 || j == 0)
               send_item(sep_pkg::ACT_WEIGHT, i[sep_pkg::INDEX_W-1:0],
                         j[sep_pkg::INDEX_W-1:0], 16'($urandom()));
      for (int j = 0; j < sep_pkg::OUT_MAX_DEF; j++)
         send_item(sep_pkg::ACT_BIAS, 4'($urandom()), j[sep_pkg::INDEX_W-1:0],
                   16'($urandom()));

      // directed table
      idle_mode = IDLE_BOTH;
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CFG) begin
            drain(DRAIN_CYCLES);
            reg_write(directed_rows[r].code, {16'h0, directed_rows[r].value});
         end else begin
            send_item(directed_rows[r].code, directed_rows[r].in_row,
                      directed_rows[r].out_col, directed_rows[r].value);
            // typed rows replace the predicted value of the result they complete
            if (directed_rows[r].has_exp) begin
               held = pending_projections.pop_back();
               held.value = directed_rows[r].exp_value;
               pending_projections.push_back(held);
            end
         end
      end

      // random phases: new register setting and idling mode per phase; widths stay on
      // the written part of the weight store
      phase = 0;
      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         drain(DRAIN_CYCLES);
         idle_mode = idle_mode_type'(phase % 4);
         case (phase)
            0:       begin iw_set = 8;  ow_set = 8;  ec_set = 1;   end
            1:       begin iw_set = 1;  ow_set = 31; ec_set = 64;  end
            2:       begin iw_set = 31; ow_set = 0;  ec_set = 127; end
            3:       begin iw_set = 4;  ow_set = 3;  ec_set = 5;   end
            default: begin
               iw_set = $urandom_range(WIDTH_SPAN, 0);
               ow_set = $urandom_range(WIDTH_SPAN, 0);
               ec_set = $urandom_range(127, 0);
            end
         endcase
         // upper data bits are random: only the low field bits may matter
         reg_write(sep_pkg::REG_IN_WIDTH, ($urandom() & 32'hFFFF_FFE0) | iw_set);
         reg_write(sep_pkg::REG_OUT_WIDTH, ($urandom() & 32'hFFFF_FFE0) | ow_set);
         reg_write(sep_pkg::REG_ENTITY_COUNT, ($urandom() & 32'hFFFF_FF80) | ec_set);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // in even phases, hold the sender mid-phase until every projection is back
            if (k == PHASE_ITEMS / 2 && phase % 2 == 0)
               drain(1);
            // mostly feature streams, with store updates and dropped transactions mixed in
            roll = $urandom_range(99, 0);
            action = (roll < 15) ? sep_pkg::ACT_WEIGHT : (roll < 25) ? sep_pkg::ACT_BIAS
                     : (roll < 30) ? ACT_UNUSED : sep_pkg::ACT_FEATURE;
            value = ($urandom_range(9, 0) == 0) ? corner[$urandom_range(3, 0)]
                                                 : 16'($urandom());
            send_item(action, 4'($urandom()), 4'($urandom()), value);
            items_sent++;
         end
         phase++;
      end

      drain(DRAIN_CYCLES);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
design/sep_pkg.sv
design/sep_ram.sv
design/sep_mac.sv
design/shared_embedding_projection.sv
tb/sv/tb_top.sv
